### hdl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, types and the microcode table for the matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = 4;
	localparam int ELEM_W    = 32;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 3;
	localparam int COND_W    = 3;
	localparam int IN_DATA_W  = ((2 * IDX_W + ELEM_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ELEM_W + 2 * IDX_W + 7) / 8) * 8;

	// input commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	// microprogram steps
	localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] S_RD   = 3'd1;
	localparam logic [STEP_W-1:0] S_MUL  = 3'd2;
	localparam logic [STEP_W-1:0] S_ACC  = 3'd3;
	localparam logic [STEP_W-1:0] S_EMIT = 3'd4;
	localparam logic [STEP_W-1:0] S_NEXT = 3'd5;
	localparam logic [STEP_W-1:0] S_DONE = 3'd6;

	// jump conditions
	localparam logic [COND_W-1:0] COND_NEVER     = 3'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
	localparam logic [COND_W-1:0] COND_NOT_START = 3'd2;
	localparam logic [COND_W-1:0] COND_K_MORE    = 3'd3;
	localparam logic [COND_W-1:0] COND_OUT_BUSY  = 3'd4;
	localparam logic [COND_W-1:0] COND_ELEM_MORE = 3'd5;

	typedef struct packed {
		logic              in_rdy;
		logic              clr_ij;
		logic              clr_acc;
		logic              rd;
		logic              mul;
		logic              acc;
		logic              emit;
		logic              adv_ij;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic [IDX_W-1:0] nr_m1;
		logic [IDX_W-1:0] nk_m1;
		logic [IDX_W-1:0] nc_m1;
	} dims_t;

	typedef struct packed {
		logic             ld_a;
		logic             ld_b;
		logic             rd;
		logic             mul;
		logic             acc;
		logic             clr_acc;
		logic             emit;
		logic             last;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} ctl_t;

	// register value to count minus one; 0 acts as 1, above MAX_DIM as MAX_DIM
	function automatic logic [IDX_W-1:0] clamp_m1(input logic [DIM_W-1:0] v);
		logic [IDX_W-1:0] r;
		begin
			if (v == '0)
				r = '0;
			else if (v > DIM_W'(MAX_DIM))
				r = IDX_W'(MAX_DIM - 1);
			else
				r = IDX_W'(v - 1'b1);
			return r;
		end
	endfunction

	// control store: one word per step
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		begin
			w = '0;
			case (step)
				S_IDLE: begin
					w.in_rdy  = 1'b1;
					w.clr_ij  = 1'b1;
					w.clr_acc = 1'b1;
					w.cond    = COND_NOT_START;
					w.target  = S_IDLE;
				end
				S_RD: begin
					w.rd = 1'b1;
				end
				S_MUL: begin
					w.mul = 1'b1;
				end
				S_ACC: begin
					w.acc    = 1'b1;
					w.cond   = COND_K_MORE;
					w.target = S_RD;
				end
				S_EMIT: begin
					w.emit   = 1'b1;
					w.cond   = COND_OUT_BUSY;
					w.target = S_EMIT;
				end
				S_NEXT: begin
					w.clr_acc = 1'b1;
					w.adv_ij  = 1'b1;
					w.cond    = COND_ELEM_MORE;
					w.target  = S_RD;
				end
				S_DONE: begin
					w.cond   = COND_ALWAYS;
					w.target = S_IDLE;
				end
				default: begin
					w.cond   = COND_ALWAYS;
					w.target = S_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

### hdl/integer_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top
// Signed matrix product C = A x B from locally loaded element stores.
// ----------------------------------------------------------------------------
// load transactions: one per cycle while the sequencer is idle, no result
// compute: per product element, read, multiply and accumulate steps of the
//   shared MAC per inner term, then emit and advance; emit waits while the
//   output register is busy, and a done step follows the last element
// output register frees the sequencer unless the sink stalls the next emit
// async reset clears the sequencer, output valid and dims to 1; stores undefined
`default_nettype none

module integer_matrix_multiply_top
	import imm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// row_index [2:0], col_index [5:3], elem_value [37:6], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd [1:0]
	input  wire logic [CMD_W-1:0]      s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// prod_value [31:0], prod_row [34:32], prod_col [37:35], zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]      cfg_data
);

	logic [DIM_W-1:0]  rows_a_q;
	logic [DIM_W-1:0]  inner_len_q;
	logic [DIM_W-1:0]  cols_b_q;
	dims_t             dims;
	ctl_t              ctl;
	logic              out_busy;
	logic [ELEM_W-1:0] out_value;
	logic [IDX_W-1:0]  out_row;
	logic [IDX_W-1:0]  out_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(1);
			inner_len_q <= DIM_W'(1);
			cols_b_q    <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_LEN: inner_len_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign dims.nr_m1 = clamp_m1(rows_a_q);
	assign dims.nk_m1 = clamp_m1(inner_len_q);
	assign dims.nc_m1 = clamp_m1(cols_b_q);

	imm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.dims     (dims),
		.out_busy (out_busy),
		.in_ready (s_axis_tready),
		.ctl      (ctl)
	);

	imm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.ld_row    (s_axis_tdata[IDX_W-1:0]),
		.ld_col    (s_axis_tdata[2*IDX_W-1:IDX_W]),
		.ld_value  (s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
		.out_ready (m_axis_tready),
		.out_busy  (out_busy),
		.out_valid (m_axis_tvalid),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - ELEM_W - 2*IDX_W){1'b0}}, out_col, out_row, out_value};

	// a compute transaction takes the sequencer out of idle
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_COMPUTE) |=> !s_axis_tready)
		else $error("input still ready after compute transaction");

	// last element sits at the far corner of the product
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> (out_row == dims.nr_m1) && (out_col == dims.nc_m1))
		else $error("last flag away from final element");

	// emitted coordinates stay inside the configured product
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_row <= dims.nr_m1) && (out_col <= dims.nc_m1))
		else $error("product coordinate out of range");

endmodule

`default_nettype wire

### hdl/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Microcoded sequencer: step counter, control store and loop counters.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_ctrl
	import imm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [CMD_W-1:0] in_cmd,
	input  wire dims_t            dims,
	input  wire logic             out_busy,
	output logic                  in_ready,
	output ctl_t                  ctl
);

	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	ucode_t            uw;
	logic              accept;
	logic              start;
	logic              k_more;
	logic              elem_last;
	logic              cond_hit;

	assign uw        = ucode_rom(step_q);
	assign in_ready  = uw.in_rdy;
	assign accept    = in_valid & uw.in_rdy;
	assign start     = accept && (in_cmd == CMD_COMPUTE);
	assign k_more    = (k_q != dims.nk_m1);
	assign elem_last = (i_q == dims.nr_m1) && (j_q == dims.nc_m1);

	always_comb begin
		case (uw.cond)
			COND_NEVER:     cond_hit = 1'b0;
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_NOT_START: cond_hit = !start;
			COND_K_MORE:    cond_hit = k_more;
			COND_OUT_BUSY:  cond_hit = out_busy;
			COND_ELEM_MORE: cond_hit = !elem_last;
			default:        cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else begin
			step_q <= cond_hit ? uw.target : step_q + 1'b1;
			if (uw.clr_ij) begin
				i_q <= '0;
				j_q <= '0;
			end else if (uw.adv_ij) begin
				if (j_q == dims.nc_m1) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (uw.clr_acc)
				k_q <= '0;
			else if (uw.acc && k_more)
				k_q <= k_q + 1'b1;
		end
	end

	always_comb begin
		ctl.ld_a    = accept && (in_cmd == CMD_LOAD_A);
		ctl.ld_b    = accept && (in_cmd == CMD_LOAD_B);
		ctl.rd      = uw.rd;
		ctl.mul     = uw.mul;
		ctl.acc     = uw.acc;
		ctl.clr_acc = uw.clr_acc;
		// hold the emit until the output register is free
		ctl.emit    = uw.emit & !out_busy;
		ctl.last    = elem_last;
		ctl.i       = i_q;
		ctl.j       = j_q;
		ctl.k       = k_q;
	end

endmodule

`default_nettype wire

### hdl/imm_dp.sv
// ----------------------------------------------------------------------------
// imm_dp
// Datapath: element stores for A and B, multiplier, accumulator, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imm_dp
	import imm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_t              ctl,
	input  wire logic [IDX_W-1:0]  ld_row,
	input  wire logic [IDX_W-1:0]  ld_col,
	input  wire logic [ELEM_W-1:0] ld_value,
	input  wire logic              out_ready,
	output logic                   out_busy,
	output logic                   out_valid,
	output logic [ELEM_W-1:0]      out_value,
	output logic [IDX_W-1:0]       out_row,
	output logic [IDX_W-1:0]       out_col,
	output logic                   out_last
);

	logic [ELEM_W-1:0] mem_a [DEPTH];
	logic [ELEM_W-1:0] mem_b [DEPTH];
	logic [ELEM_W-1:0] a_q;
	logic [ELEM_W-1:0] b_q;
	logic [ELEM_W-1:0] prod_q;
	logic [ELEM_W-1:0] acc_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;

	assign wr_addr   = {ld_row, ld_col};
	assign rd_addr_a = {ctl.i, ctl.k};
	assign rd_addr_b = {ctl.k, ctl.j};

	always_ff @(posedge clk) begin
		if (ctl.ld_a)
			mem_a[wr_addr] <= ld_value;
		if (ctl.rd)
			a_q <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_b)
			mem_b[wr_addr] <= ld_value;
		if (ctl.rd)
			b_q <= mem_b[rd_addr_b];
	end

	// low word of the product is the same for signed and unsigned operands
	always_ff @(posedge clk) begin
		if (ctl.mul)
			prod_q <= a_q * b_q;
		if (ctl.clr_acc)
			acc_q <= '0;
		else if (ctl.acc)
			acc_q <= acc_q + prod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_value <= acc_q;
			out_row   <= ctl.i;
			out_col   <= ctl.j;
			out_last  <= ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q & !out_ready;

endmodule

`default_nettype wire

### dv/product_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// product_checker
// Watches the load/compute stream, the product stream and the register port
// of the matrix multiplier. Keeps its own copy of both element stores and of
// the dimensions, works out every product element when a compute transaction
// is accepted, and compares each product transaction with the oldest one.
// ----------------------------------------------------------------------------
module product_checker
	import imm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	// row_index [2:0], col_index [5:3], elem_value [37:6], zero pad
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	// cmd [1:0]
	input  wire logic [CMD_W-1:0]     s_axis_tuser,
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// prod_value [31:0], prod_row [34:32], prod_col [37:35], zero pad
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                 m_axis_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	output int unsigned               mismatch_count,
	output int unsigned               pending_count,
	output int unsigned               checked_count
);

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} product_t;

	logic [ELEM_W-1:0] a_elems [DEPTH];
	logic [ELEM_W-1:0] b_elems [DEPTH];
	logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
	product_t          expected_products [$];

	// 0 acts as 1, anything above the store size as the store size
	function automatic int dim_count(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > DIM_W'(MAX_DIM))
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void queue_products();
		int nr, nk, nc;
		logic [ELEM_W-1:0] sum;
		product_t p;
		nr = dim_count(rows_reg);
		nk = dim_count(inner_reg);
		nc = dim_count(cols_reg);
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				sum = '0;
				// products and sum keep the low 32 bits
				for (int k = 0; k < nk; k++)
					sum = sum + a_elems[i * MAX_DIM + k] * b_elems[k * MAX_DIM + j];
				p.value = sum;
				p.row   = IDX_W'(i);
				p.col   = IDX_W'(j);
				p.last  = (i == nr - 1) && (j == nc - 1);
				expected_products.push_back(p);
			end
		end
	endfunction

	function automatic void check_product();
		product_t got, want;
		got.value = m_axis_tdata[ELEM_W-1:0];
		got.row   = m_axis_tdata[ELEM_W +: IDX_W];
		got.col   = m_axis_tdata[ELEM_W + IDX_W +: IDX_W];
		got.last  = m_axis_tlast;
		if (expected_products.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%t unexpected product: value %h row %0d col %0d last %b",
					$realtime, got.value, got.row, got.col, got.last);
			return;
		end
		want = expected_products.pop_front();
		checked_count++;
		if (got != want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%t product mismatch: expected %h (%0d,%0d) last %b, got %h (%0d,%0d) last %b",
					$realtime, want.value, want.row, want.col, want.last,
					got.value, got.row, got.col, got.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = DIM_W'(1);
			inner_reg = DIM_W'(1);
			cols_reg = DIM_W'(1);
			expected_products.delete();
			mismatch_count = 0;
			checked_count = 0;
			pending_count = 0;
		end else begin
			// a product can never stem from a compute accepted at the same edge
			if (m_axis_tvalid && m_axis_tready)
				check_product();
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_A:    rows_reg = cfg_data;
					REG_INNER_LEN: inner_reg = cfg_data;
					REG_COLS_B:    cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					CMD_LOAD_A: a_elems[s_axis_tdata[IDX_W-1:0] * MAX_DIM
						+ s_axis_tdata[IDX_W +: IDX_W]] = s_axis_tdata[2 * IDX_W +: ELEM_W];
					CMD_LOAD_B: b_elems[s_axis_tdata[IDX_W-1:0] * MAX_DIM
						+ s_axis_tdata[IDX_W +: IDX_W]] = s_axis_tdata[2 * IDX_W +: ELEM_W];
					CMD_COMPUTE: queue_products();
					default: ;
				endcase
			end
			pending_count = expected_products.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Loads element stores and requests products from the matrix multiplier over
// a series of dimension settings, with sender gaps, receiver stalls and one
// long output hold; the product checker judges every product transaction.
// ----------------------------------------------------------------------------
module tb;
	import imm_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS    = 140;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_CYCLES     = 400;
	localparam int PRESSURE_PHASE  = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [CMD_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIM_W-1:0]      cfg_data;

	int unsigned mismatch_count, pending_count, checked_count;

	int               send_idle_pct, recv_stall_pct;
	bit               pressure_req;
	bit               a_written [DEPTH];
	bit               b_written [DEPTH];
	logic [DIM_W-1:0] rows_cfg, inner_cfg, cols_cfg;
	int               load_count, compute_count, setting_count, rand_items;

	integer_matrix_multiply_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	product_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// product sink: random stalls, plus one long hold while a compute is running
	initial begin : product_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic int active_dim(input logic [DIM_W-1:0] v);
		return (v == '0) ? 1 : (v > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(v);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(0, 9) < 8)
			return DIM_W'($urandom_range(0, 4));
		return DIM_W'($urandom_range(9, 15));
	endfunction

	function automatic logic [ELEM_W-1:0] pick_elem();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return ELEM_W'($urandom_range(0, 16)) - ELEM_W'(8);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_DATA_W'({v, c, r});
		do @(posedge clk); while (!s_axis_tready);
		rand_items++;
		if (cmd == CMD_LOAD_A) begin
			a_written[r * MAX_DIM + c] = 1'b1;
			load_count++;
		end else if (cmd == CMD_LOAD_B) begin
			b_written[r * MAX_DIM + c] = 1'b1;
			load_count++;
		end
	endtask

	// fill whatever the current product reads and has not been loaded yet
	task automatic run_compute();
		int nr, nk, nc;
		nr = active_dim(rows_cfg);
		nk = active_dim(inner_cfg);
		nc = active_dim(cols_cfg);
		for (int i = 0; i < nr; i++)
			for (int k = 0; k < nk; k++)
				if (!a_written[i * MAX_DIM + k])
					send_item(CMD_LOAD_A, IDX_W'(i), IDX_W'(k), pick_elem());
		for (int k = 0; k < nk; k++)
			for (int j = 0; j < nc; j++)
				if (!b_written[k * MAX_DIM + j])
					send_item(CMD_LOAD_B, IDX_W'(k), IDX_W'(j), pick_elem());
		send_item(CMD_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
		compute_count++;
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
			input logic [DIM_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_INNER_LEN;
		cfg_data <= k;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_cfg = r;
		inner_cfg = k;
		cols_cfg = c;
		setting_count++;
	endtask

	// block is idle once every product is back and the sequencer has wound down
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase, mode, kind, nr, nk, nc;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_LOAD_A;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS_A;
		cfg_data <= '0;
		pressure_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rows_cfg = DIM_W'(1);
		inner_cfg = DIM_W'(1);
		cols_cfg = DIM_W'(1);
		load_count = 0;
		compute_count = 0;
		setting_count = 0;
		rand_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimensions 1x1x1: most negative times -1 wraps back to itself
		send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
		send_item(CMD_LOAD_B, 3'd0, 3'd0, '1);
		run_compute();
		send_item(CMD_UNUSED, 3'd7, 3'd7, '1);
		send_item(CMD_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
		send_item(CMD_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
		send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
		send_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
		run_compute();
		drain();

		// write to the spare index must leave the dimensions alone
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_0003);
		run_compute();
		drain();

		// zero dimensions act as one
		set_dims('0, '0, '0);
		send_item(CMD_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFE);
		run_compute();
		drain();

		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			case (phase)
				0: set_dims('1, 4'd3, 4'd2);
				1: set_dims(4'd2, 4'd3, 4'd4);
				2: set_dims(4'd8, 4'd2, 4'd8);
				3: set_dims(4'd1, 4'd8, 4'd1);
				default: set_dims(pick_dim(), pick_dim(), pick_dim());
			endcase
			mode = phase % 4;
			send_idle_pct = (mode == 1) ? 62 : (mode == 3) ? 34 : 0;
			recv_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 34 : 0;
			nr = active_dim(rows_cfg);
			nk = active_dim(inner_cfg);
			nc = active_dim(cols_cfg);
			// long output hold while 64 products are pending, loads pile up behind
			if (phase == PRESSURE_PHASE) begin
				pressure_req = 1'b1;
				run_compute();
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				kind = $urandom_range(0, 99);
				if (kind < 40)
					send_item(CMD_LOAD_A, IDX_W'($urandom_range(0, nr - 1)),
						IDX_W'($urandom_range(0, nk - 1)), pick_elem());
				else if (kind < 80)
					send_item(CMD_LOAD_B, IDX_W'($urandom_range(0, nk - 1)),
						IDX_W'($urandom_range(0, nc - 1)), pick_elem());
				else if (kind < 86)
					send_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
						IDX_W'($urandom()), IDX_W'($urandom()), pick_elem());
				else if (kind < 90)
					send_item(CMD_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
				else
					run_compute();
			end
			run_compute();
			drain();
			phase++;
		end

		$display("covered %0d element loads and %0d products over %0d dimension settings",
			load_count, compute_count, setting_count);
		$display("with sender gaps, sink stalls and a long sink hold; %0d elements checked",
			checked_count);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
